// ===== design/dita_pkg.sv =====
// Shared types and constants for the device identifier table allocator.
package dita_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int RESERVE_DEPTH_DEF = 64;
  localparam int HANDLE_BITS_DEF   = 16;

  // Field widths fixed by the interface
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int HND_W    = 16;
  localparam int MANU_W   = 16;
  localparam int DEV_W    = 32;
  localparam int KEY_W    = 64;
  localparam int UID_W    = MANU_W + DEV_W;
  localparam int MAXID_W  = 7;
  localparam int IN_DW    = HND_W + MANU_W + DEV_W + 2 * KEY_W;
  localparam int OUT_DW   = HND_W + MANU_W + DEV_W;

  localparam logic [MAXID_W-1:0] MAXID_RESET = 7'd64;
  localparam logic [DEV_W-1:0]   DEV_NUM_RESET = 32'd1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD_STATIC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_DYNAMIC = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE      = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP      = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_CAPACITY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RRD,
    S_RCMP,
    S_RDEC,
    S_RUID,
    S_NUM,
    S_TRD,
    S_TCMP,
    S_TDONE,
    S_INFO,
    S_OUT
  } state_t;

endpackage

// ===== design/device_id_table_allocator_top.sv =====
// Top level of the device identifier table allocator.
// Lookup, remove and static add scan the table one entry at a time, a read state and then a
// compare state per entry; the result is held back further while out_tready stalls.
// Dynamic add scans the reservation store first, then the table once per identifier tried.
// Throughput: one item at a time; the next item is taken while the last result waits.
// Reset: synchronous, active low; clears valid bits, counts and the sequencer, no sweep.
module device_id_table_allocator_top #(
  parameter int TABLE_DEPTH   = dita_pkg::TABLE_DEPTH_DEF,
  parameter int RESERVE_DEPTH = dita_pkg::RESERVE_DEPTH_DEF,
  parameter int HANDLE_BITS   = dita_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: owner_handle, uid_manufacturer, uid_device, client_key_high, client_key_low
  input  logic [dita_pkg::IN_DW-1:0]    in_tdata,
  // in_tuser: action
  input  logic [dita_pkg::ACT_W-1:0]    in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: found_handle, assigned_manufacturer, assigned_device
  output logic [dita_pkg::OUT_DW-1:0]   out_tdata,
  // out_tuser: status
  output logic [dita_pkg::STAT_W-1:0]   out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [dita_pkg::MAXID_W-1:0]  cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RIDX_W = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1;
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RCNT_W = $clog2(RESERVE_DEPTH + 1);
  localparam int SI_W   = (TIDX_W > RIDX_W) ? TIDX_W : RIDX_W;
  localparam int INFO_W = HANDLE_BITS + 1 + RIDX_W;
  localparam int UID_W  = dita_pkg::UID_W;
  localparam int DEV_W  = dita_pkg::DEV_W;
  localparam int MANU_W = dita_pkg::MANU_W;
  localparam int KEY_W  = dita_pkg::KEY_W;

  // Memories
  logic [UID_W-1:0]    tkey_mem [TABLE_DEPTH];
  logic [INFO_W-1:0]   info_mem [TABLE_DEPTH];
  logic [2*KEY_W-1:0]  rkey_mem [RESERVE_DEPTH];
  logic [UID_W-1:0]    ruid_mem [RESERVE_DEPTH];
  logic [UID_W-1:0]    tkey_rd_r;
  logic [INFO_W-1:0]   info_rd_r;
  logic [2*KEY_W-1:0]  rkey_rd_r;
  logic [UID_W-1:0]    ruid_rd_r;

  // Valid and connected bits
  logic [TABLE_DEPTH-1:0]   evalid_r;
  logic [RESERVE_DEPTH-1:0] rvalid_r;
  logic [RESERVE_DEPTH-1:0] conn_r;

  dita_pkg::state_t state_r, state_nxt;

  logic [dita_pkg::ACT_W-1:0]   act_r, act_nxt;
  logic [HANDLE_BITS-1:0]       hnd_r, hnd_nxt;
  logic [MANU_W-1:0]            manu_r, manu_nxt;
  logic [2*KEY_W-1:0]           ckey_r, ckey_nxt;
  logic [UID_W-1:0]             key_r, key_nxt;
  logic [SI_W-1:0]              idx_r, idx_nxt;
  logic                         hit_r, hit_nxt;
  logic [TIDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic                         free_ok_r, free_ok_nxt;
  logic [TIDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic                         rhit_r, rhit_nxt;
  logic [RIDX_W-1:0]            ridx_r, ridx_nxt;
  logic [TCNT_W-1:0]            ecount_r, ecount_nxt;
  logic [RCNT_W-1:0]            rcount_r, rcount_nxt;
  logic [DEV_W-1:0]             devnum_r, devnum_nxt;
  logic [dita_pkg::MAXID_W-1:0] maxid_r;
  logic [dita_pkg::STAT_W-1:0]  stat_r, stat_nxt;
  logic [dita_pkg::HND_W-1:0]   found_r, found_nxt;
  logic [UID_W-1:0]             given_r, given_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dita_pkg::STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [dita_pkg::OUT_DW-1:0]  odata_r, odata_nxt;

  // Memory and bit write controls
  logic                 st_we;
  logic                 st_hasres;
  logic [RIDX_W-1:0]    st_res;
  logic                 ev_clr;
  logic                 rs_we;
  logic [RIDX_W-1:0]    rs_idx;
  logic                 conn_set;
  logic [RIDX_W-1:0]    conn_set_idx;
  logic                 conn_clr;
  logic [RIDX_W-1:0]    conn_clr_idx;

  // Derived tests
  logic                 full;
  logic                 rstore_full;
  logic                 tmatch;
  logic                 rmatch;
  logic                 tlast;
  logic                 rlast;
  logic [HANDLE_BITS-1:0] info_hnd;
  logic                 info_hasres;
  logic [RIDX_W-1:0]    info_res;

  assign full = (32'(ecount_r) >= 32'(maxid_r)) || (32'(ecount_r) >= 32'(TABLE_DEPTH));
  assign rstore_full = 32'(rcount_r) >= 32'(RESERVE_DEPTH);
  assign tmatch = evalid_r[idx_r[TIDX_W-1:0]] && (tkey_rd_r == key_r);
  assign rmatch = rvalid_r[idx_r[RIDX_W-1:0]] && (rkey_rd_r == ckey_r);
  assign tlast = idx_r == SI_W'(TABLE_DEPTH - 1);
  assign rlast = idx_r == SI_W'(RESERVE_DEPTH - 1);
  assign {info_hnd, info_hasres, info_res} = info_rd_r;

  assign in_tready  = state_r == dita_pkg::S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;

  // Table memories: write on store, registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      tkey_mem[free_idx_r] <= key_r;
      info_mem[free_idx_r] <= {hnd_r, st_hasres, st_res};
    end
    tkey_rd_r <= tkey_mem[idx_r[TIDX_W-1:0]];
    info_rd_r <= info_mem[hit_idx_r];
  end

  // Reservation memories
  always_ff @(posedge clk) begin
    if (rs_we) begin
      rkey_mem[rs_idx] <= ckey_r;
      ruid_mem[rs_idx] <= key_r;
    end
    rkey_rd_r <= rkey_mem[idx_r[RIDX_W-1:0]];
    ruid_rd_r <= ruid_mem[ridx_r];
  end

  // Valid and connected bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evalid_r <= '0;
      rvalid_r <= '0;
      conn_r   <= '0;
    end else begin
      if (st_we) evalid_r[free_idx_r] <= 1'b1;
      if (ev_clr) evalid_r[hit_idx_r] <= 1'b0;
      if (rs_we) rvalid_r[rs_idx] <= 1'b1;
      if (conn_set) conn_r[conn_set_idx] <= 1'b1;
      if (conn_clr) conn_r[conn_clr_idx] <= 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxid_r <= dita_pkg::MAXID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      maxid_r <= cfg_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dita_pkg::S_IDLE;
      ecount_r    <= '0;
      rcount_r    <= '0;
      devnum_r    <= dita_pkg::DEV_NUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ecount_r    <= ecount_nxt;
      rcount_r    <= rcount_nxt;
      devnum_r    <= devnum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    hnd_r      <= hnd_nxt;
    manu_r     <= manu_nxt;
    ckey_r     <= ckey_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_ok_r  <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    rhit_r     <= rhit_nxt;
    ridx_r     <= ridx_nxt;
    stat_r     <= stat_nxt;
    found_r    <= found_nxt;
    given_r    <= given_nxt;
    ostat_r    <= ostat_nxt;
    odata_r    <= odata_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    hnd_nxt       = hnd_r;
    manu_nxt      = manu_r;
    ckey_nxt      = ckey_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    rhit_nxt      = rhit_r;
    ridx_nxt      = ridx_r;
    ecount_nxt    = ecount_r;
    rcount_nxt    = rcount_r;
    devnum_nxt    = devnum_r;
    stat_nxt      = stat_r;
    found_nxt     = found_r;
    given_nxt     = given_r;
    out_valid_nxt = out_valid_r;
    ostat_nxt     = ostat_r;
    odata_nxt     = odata_r;
    st_we         = 1'b0;
    st_hasres     = 1'b0;
    st_res        = ridx_r;
    ev_clr        = 1'b0;
    rs_we         = 1'b0;
    rs_idx        = rcount_r[RIDX_W-1:0];
    conn_set      = 1'b0;
    conn_set_idx  = ridx_r;
    conn_clr      = 1'b0;
    conn_clr_idx  = info_res;

    // Output stage drains independently
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      dita_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          hnd_nxt   = HANDLE_BITS'(in_tdata[15:0]);
          manu_nxt  = in_tdata[31:16];
          // identifier: manufacturer on top, device number below
          key_nxt   = {in_tdata[31:16], in_tdata[63:32]};
          ckey_nxt  = in_tdata[191:64];
          stat_nxt  = dita_pkg::ST_OK;
          found_nxt = '0;
          given_nxt = '0;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          rhit_nxt  = 1'b0;
          case (in_tuser)
            dita_pkg::ACT_ADD_STATIC: begin
              if (full) begin
                stat_nxt  = dita_pkg::ST_CAPACITY;
                state_nxt = dita_pkg::S_OUT;
              end else begin
                state_nxt = dita_pkg::S_TRD;
              end
            end
            dita_pkg::ACT_ADD_DYNAMIC: state_nxt = dita_pkg::S_RRD;
            default: state_nxt = dita_pkg::S_TRD;
          endcase
        end
      end

      // Reservation scan by client key
      dita_pkg::S_RRD: state_nxt = dita_pkg::S_RCMP;
      dita_pkg::S_RCMP: begin
        if (rmatch) begin
          rhit_nxt  = 1'b1;
          ridx_nxt  = idx_r[RIDX_W-1:0];
          state_nxt = dita_pkg::S_RDEC;
        end else if (rlast) begin
          state_nxt = dita_pkg::S_RDEC;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = dita_pkg::S_RRD;
        end
      end
      dita_pkg::S_RDEC: begin
        if (full) begin
          stat_nxt  = dita_pkg::ST_CAPACITY;
          state_nxt = dita_pkg::S_OUT;
        end else if (rhit_r) begin
          if (conn_r[ridx_r]) begin
            stat_nxt  = dita_pkg::ST_DUPLICATE;
            state_nxt = dita_pkg::S_OUT;
          end else begin
            state_nxt = dita_pkg::S_RUID;
          end
        end else if (rstore_full) begin
          stat_nxt  = dita_pkg::ST_CAPACITY;
          state_nxt = dita_pkg::S_OUT;
        end else begin
          state_nxt = dita_pkg::S_NUM;
        end
      end
      // Returning client: reserved identifier comes back
      dita_pkg::S_RUID: begin
        key_nxt     = ruid_rd_r;
        conn_set    = 1'b1;
        idx_nxt     = '0;
        hit_nxt     = 1'b0;
        free_ok_nxt = 1'b0;
        state_nxt   = dita_pkg::S_TRD;
      end
      // Next device number, zero skipped
      dita_pkg::S_NUM: begin
        devnum_nxt = devnum_r + 1'b1;
        if (devnum_r != '0) begin
          key_nxt     = {manu_r, devnum_r};
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt   = dita_pkg::S_TRD;
        end
      end

      // Table scan for key_r, first free slot noted
      dita_pkg::S_TRD: state_nxt = dita_pkg::S_TCMP;
      dita_pkg::S_TCMP: begin
        if (!evalid_r[idx_r[TIDX_W-1:0]] && !free_ok_r) begin
          free_ok_nxt  = 1'b1;
          free_idx_nxt = idx_r[TIDX_W-1:0];
        end
        if (tmatch) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r[TIDX_W-1:0];
          state_nxt   = dita_pkg::S_TDONE;
        end else if (tlast) begin
          state_nxt = dita_pkg::S_TDONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = dita_pkg::S_TRD;
        end
      end
      dita_pkg::S_TDONE: begin
        state_nxt = dita_pkg::S_OUT;
        case (act_r)
          dita_pkg::ACT_ADD_STATIC: begin
            if (hit_r) begin
              stat_nxt = dita_pkg::ST_DUPLICATE;
            end else begin
              st_we      = 1'b1;
              ecount_nxt = ecount_r + 1'b1;
            end
          end
          dita_pkg::ACT_ADD_DYNAMIC: begin
            if (rhit_r) begin
              given_nxt = key_r;
              if (!hit_r) begin
                st_we      = 1'b1;
                st_hasres  = 1'b1;
                ecount_nxt = ecount_r + 1'b1;
              end
            end else if (hit_r) begin
              state_nxt = dita_pkg::S_NUM;
            end else begin
              rs_we        = 1'b1;
              conn_set     = 1'b1;
              conn_set_idx = rcount_r[RIDX_W-1:0];
              rcount_nxt   = rcount_r + 1'b1;
              st_we        = 1'b1;
              st_hasres    = 1'b1;
              st_res       = rcount_r[RIDX_W-1:0];
              ecount_nxt   = ecount_r + 1'b1;
              given_nxt    = key_r;
            end
          end
          default: begin
            if (hit_r) begin
              state_nxt = dita_pkg::S_INFO;
            end else begin
              stat_nxt = dita_pkg::ST_NOT_FOUND;
            end
          end
        endcase
      end
      // Entry info read back for lookup and remove
      dita_pkg::S_INFO: begin
        state_nxt = dita_pkg::S_OUT;
        if (act_r == dita_pkg::ACT_LOOKUP) begin
          found_nxt = dita_pkg::HND_W'(info_hnd);
        end else begin
          conn_clr   = info_hasres;
          ev_clr     = 1'b1;
          ecount_nxt = ecount_r - 1'b1;
        end
      end
      // Result into the output register once it is free
      dita_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          ostat_nxt     = stat_r;
          odata_nxt     = {given_r[DEV_W-1:0], given_r[UID_W-1:DEV_W], found_r};
          state_nxt     = dita_pkg::S_IDLE;
        end
      end
      default: state_nxt = dita_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/dita_checker.sv =====
// Port-level checks for the device identifier table allocator, bound to the top level.
module dita_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [dita_pkg::OUT_DW-1:0]   out_tdata,
  input logic [dita_pkg::STAT_W-1:0]   out_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  // No result appears right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A failed request carries no handle and no identifier
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dita_pkg::ST_OK |-> out_tdata == '0)
    else $error("nonzero payload on failed request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // One item at a time: no new transfer in the cycle right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

endmodule

bind device_id_table_allocator_top dita_checker u_dita_checker (.*);
